@@ design/mau_pkg.sv @@
package mau_pkg;
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_POW = 3'd3,
		OP_INV = 3'd4,
		OP_DIV = 3'd5
	} opcode_t;

	localparam int unsigned ADDR_WIDTH = 3;
	localparam logic [ADDR_WIDTH-1:0] REG_MODULUS = 3'd0;
	localparam longint unsigned MODULUS_RESET = 64'd1000000007;
endpackage

@@ design/modular_arithmetic_unit.sv @@
// Channel   Handshake                 Words
// input     start / busy              opcode, operand_a, operand_b
// result    done strobe, one cycle    result
// config    APB write, pready high    modulus at byte address 0
// Each word first has both operands reduced modulo the modulus by the serial reducers.
// Power, inverse and divide then run max(OPERAND_WIDTH, MODULUS_WIDTH) exponent steps,
// each one or two serial modular multiplies.
// A two-word queue holds accepted words; busy is high while it is full.
// Reset sets the modulus to 1000000007 and empties the queue; results cannot be stalled.
module modular_arithmetic_unit #(
	parameter int unsigned MODULUS_WIDTH = 31,
	parameter int unsigned OPERAND_WIDTH = 63
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mau_pkg::ADDR_WIDTH-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         opcode,
	input  logic [OPERAND_WIDTH-1:0]           operand_a,
	input  logic [OPERAND_WIDTH-1:0]           operand_b,
	output logic                               done,
	output logic [MODULUS_WIDTH-1:0]           result
);
	import mau_pkg::*;

	logic [MODULUS_WIDTH-1:0] mod_q;
	logic                     q_valid, q_pop;
	logic [2:0]               q_opcode;
	logic [OPERAND_WIDTH-1:0] q_a, q_b;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_MODULUS) ? 32'(mod_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_WIDTH'(MODULUS_RESET);
		end else if (psel && penable && pwrite && paddr == REG_MODULUS) begin
			mod_q <= pwdata[MODULUS_WIDTH-1:0];
		end
	end

	mau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.operand_a(operand_a), .operand_b(operand_b), .q_valid(q_valid), .q_pop(q_pop),
		.q_opcode(q_opcode), .q_a(q_a), .q_b(q_b)
	);

	mau_back #(.MODULUS_WIDTH(MODULUS_WIDTH), .OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .m(mod_q), .q_valid(q_valid), .q_pop(q_pop),
		.q_opcode(q_opcode), .q_a(q_a), .q_b(q_b), .done(done), .result(result)
	);
endmodule

@@ design/mau_front.sv @@
module mau_front #(
	parameter int unsigned OPERAND_WIDTH = 63
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               opcode,
	input  logic [OPERAND_WIDTH-1:0] operand_a,
	input  logic [OPERAND_WIDTH-1:0] operand_b,
	output logic                     q_valid,
	input  logic                     q_pop,
	output logic [2:0]               q_opcode,
	output logic [OPERAND_WIDTH-1:0] q_a,
	output logic [OPERAND_WIDTH-1:0] q_b
);
	import mau_pkg::*;

	logic [2:0]               op_q [2];
	logic [OPERAND_WIDTH-1:0] a_q [2];
	logic [OPERAND_WIDTH-1:0] b_q [2];
	logic                     wr_q, rd_q;
	logic [1:0]               cnt_q;
	logic                     push;

	assign busy     = (cnt_q == 2'd2);
	assign push     = start && !busy;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_opcode = op_q[rd_q];
	assign q_a      = a_q[rd_q];
	assign q_b      = b_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_q] <= opcode;
			a_q[wr_q]  <= operand_a;
			b_q[wr_q]  <= operand_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end
endmodule

@@ design/mau_mulmod.sv @@
module mau_mulmod #(
	parameter int unsigned MODULUS_WIDTH = 31
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [MODULUS_WIDTH-1:0] x,
	input  logic [MODULUS_WIDTH-1:0] y,
	input  logic [MODULUS_WIDTH-1:0] m,
	output logic                     fin,
	output logic [MODULUS_WIDTH-1:0] p
);
	import mau_pkg::*;

	localparam int unsigned MW = MODULUS_WIDTH;
	localparam int unsigned CW = $clog2(MW);

	logic [MW-1:0] acc_q, x_q, y_q;
	logic [CW-1:0] cnt_q;
	logic          run_q, fin_q;
	logic [MW:0]   d, d1, e, e1;

	always_comb begin
		d  = {acc_q, 1'b0};
		d1 = (d >= {1'b0, m}) ? d - {1'b0, m} : d;
		e  = d1 + (y_q[MW-1] ? {1'b0, x_q} : '0);
		e1 = (e >= {1'b0, m}) ? e - {1'b0, m} : e;
	end

	assign p   = acc_q;
	assign fin = fin_q;

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (run_q) begin
			acc_q <= e1[MW-1:0];
			y_q   <= {y_q[MW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MW - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end
endmodule

@@ design/mau_back.sv @@
module mau_back #(
	parameter int unsigned MODULUS_WIDTH = 31,
	parameter int unsigned OPERAND_WIDTH = 63
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [MODULUS_WIDTH-1:0] m,
	input  logic                     q_valid,
	output logic                     q_pop,
	input  logic [2:0]               q_opcode,
	input  logic [OPERAND_WIDTH-1:0] q_a,
	input  logic [OPERAND_WIDTH-1:0] q_b,
	output logic                     done,
	output logic [MODULUS_WIDTH-1:0] result
);
	import mau_pkg::*;

	localparam int unsigned MW = MODULUS_WIDTH;
	localparam int unsigned OW = OPERAND_WIDTH;
	localparam int unsigned EW = (OW > MW) ? OW : MW;
	localparam int unsigned CW = $clog2(EW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RED, S_EXEC, S_SQ, S_SQW, S_ML, S_MLW, S_NXT, S_FIN, S_DONE
	} state_t;

	state_t        state_q;
	logic [2:0]    op_q;
	logic [OW-1:0] sa_q, sb_q;
	logic [OW-1:0] b_full_q;
	logic [EW-1:0] exp_q;
	logic [MW-1:0] ra_q, rb_q, acc_q, base_q, res_q, mx_q, my_q;
	logic [CW-1:0] cnt_q;
	logic          go_q, done_q, mfin;
	logic [MW-1:0] mp;
	logic [MW:0]   ta, tb, sum;

	mau_mulmod #(.MODULUS_WIDTH(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .go(go_q), .x(mx_q), .y(my_q), .m(m),
		.fin(mfin), .p(mp)
	);

	always_comb begin
		ta  = {ra_q, sa_q[OW-1]};
		ta  = (ta >= {1'b0, m}) ? ta - {1'b0, m} : ta;
		tb  = {rb_q, sb_q[OW-1]};
		tb  = (tb >= {1'b0, m}) ? tb - {1'b0, m} : tb;
		sum = {1'b0, ra_q} + {1'b0, rb_q};
		sum = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
	end

	assign q_pop  = (state_q == S_IDLE) && q_valid;
	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) b_full_q <= q_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						op_q    <= q_opcode;
						sa_q    <= q_a;
						sb_q    <= q_b;
						ra_q    <= '0;
						rb_q    <= '0;
						cnt_q   <= '0;
						state_q <= S_RED;
					end
				end
				S_RED: begin
					ra_q  <= ta[MW-1:0];
					rb_q  <= tb[MW-1:0];
					sa_q  <= {sa_q[OW-2:0], 1'b0};
					sb_q  <= {sb_q[OW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(OW - 1)) state_q <= S_EXEC;
				end
				S_EXEC: begin
					acc_q <= MW'(1);
					cnt_q <= '0;
					state_q <= S_SQ;
					exp_q <= EW'(m - MW'(2));
					base_q <= ra_q;
					if (m < MW'(2) || op_q > OP_DIV) begin
						res_q   <= '0;
						state_q <= S_DONE;
					end else begin
						unique case (op_q)
							OP_ADD: begin
								res_q   <= sum[MW-1:0];
								state_q <= S_DONE;
							end
							OP_SUB: begin
								res_q   <= (ra_q >= rb_q) ? ra_q - rb_q : ra_q + (m - rb_q);
								state_q <= S_DONE;
							end
							OP_MUL: begin
								mx_q    <= ra_q;
								my_q    <= rb_q;
								go_q    <= 1'b1;
								state_q <= S_FIN;
							end
							OP_POW: exp_q <= EW'(b_full_q);
							OP_DIV: base_q <= rb_q;
							default: ;
						endcase
					end
				end
				S_SQ: begin
					mx_q    <= acc_q;
					my_q    <= acc_q;
					go_q    <= 1'b1;
					state_q <= S_SQW;
				end
				S_SQW: begin
					if (mfin) begin
						acc_q   <= mp;
						state_q <= exp_q[EW-1] ? S_ML : S_NXT;
					end
				end
				S_ML: begin
					mx_q    <= acc_q;
					my_q    <= base_q;
					go_q    <= 1'b1;
					state_q <= S_MLW;
				end
				S_MLW: begin
					if (mfin) begin
						acc_q   <= mp;
						state_q <= S_NXT;
					end
				end
				S_NXT: begin
					exp_q <= {exp_q[EW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(EW - 1)) begin
						if (op_q == OP_DIV) begin
							mx_q    <= ra_q;
							my_q    <= acc_q;
							go_q    <= 1'b1;
							state_q <= S_FIN;
						end else begin
							res_q   <= acc_q;
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_SQ;
					end
				end
				S_FIN: begin
					if (mfin) begin
						res_q   <= mp;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/mau_checker.sv @@
module mau_checker #(
	parameter int unsigned MODULUS_WIDTH = 31
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     pready,
	input logic                     done,
	input logic [MODULUS_WIDTH-1:0] result
);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held two cycles");
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result != {MODULUS_WIDTH{1'b1}})
		else $error("result out of range");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind modular_arithmetic_unit mau_checker #(.MODULUS_WIDTH(MODULUS_WIDTH)) u_mau_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pready(pready),
	.done(done), .result(result)
);

@@ sim/modular_arithmetic_unit_tb.sv @@
`timescale 1ns / 100ps

module modular_arithmetic_unit_tb;
	import mau_pkg::*;

	localparam int unsigned MW = 31;
	localparam int unsigned OW = 63;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [2:0] opcode;
	logic [OW-1:0] operand_a;
	logic [OW-1:0] operand_b;
	logic done;
	logic [MW-1:0] result;

	modular_arithmetic_unit #(.MODULUS_WIDTH(MW), .OPERAND_WIDTH(OW)) dut (.*);

	class residue_scoreboard;
		longint unsigned modulus;
		logic [MW-1:0] expected_residues[$];
		int errors;

		function new();
			modulus = MODULUS_RESET;
			errors = 0;
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
			errors++;
		endtask

		function longint unsigned power_residue(longint unsigned base,
				logic [63:0] expo, longint unsigned m);
			longint unsigned acc;
			acc = 1 % m;
			for (int i = 63; i >= 0; i--) begin
				acc = (acc * acc) % m;
				if (expo[i])
					acc = (acc * base) % m;
			end
			return acc;
		endfunction

		function void note_word(logic [2:0] op, logic [OW-1:0] a, logic [OW-1:0] b);
			longint unsigned m;
			longint unsigned ra;
			longint unsigned rb;
			longint unsigned r;
			m = modulus;
			r = 0;
			if (m >= 2) begin
				ra = longint'(a) % m;
				rb = longint'(b) % m;
				case (opcode_t'(op))
					OP_ADD: r = (ra + rb) % m;
					OP_SUB: r = (ra + m - rb) % m;
					OP_MUL: r = (ra * rb) % m;
					OP_POW: r = power_residue(ra, {1'b0, b}, m);
					OP_INV: r = power_residue(ra, m - 2, m);
					OP_DIV: r = (ra * power_residue(rb, m - 2, m)) % m;
					default: r = 0;
				endcase
			end
			expected_residues = {expected_residues, r[MW-1:0]};
		endfunction

		task check_result(logic [MW-1:0] got);
			logic [MW-1:0] want;
			if (expected_residues.size() == 0) begin
				report_mismatch("unexpected result", got, 0);
			end else begin
				want = expected_residues.pop_front();
				if (got !== want)
					report_mismatch("result", got, want);
			end
		endtask
	endclass

	residue_scoreboard sb;
	bit quiet_tail;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	task wait_drained();
		while (sb.expected_residues.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task write_modulus(logic [31:0] value);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_MODULUS; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0;
		sb.modulus = value[MW-1:0];
		pwrite <= 0; psel <= 1; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata[MW-1:0] !== sb.modulus[MW-1:0])
			sb.report_mismatch("modulus readback", prdata, sb.modulus);
		psel <= 0; penable <= 0;
	endtask

	task send_word(logic [2:0] op, logic [OW-1:0] a, logic [OW-1:0] b);
		start <= 1; opcode <= op; operand_a <= a; operand_b <= b;
		do @(posedge clk); while (busy);
		sb.note_word(op, a, b);
	endtask

	task maybe_idle();
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	function logic [OW-1:0] rand_operand();
		logic [OW-1:0] v;
		v = OW'({$urandom, $urandom});
		case ($urandom_range(0, 4))
			0: v = v & 63'hff;
			1: v = v & 63'h7fff_ffff;
			2: v = '1 - OW'($urandom_range(0, 3));
			default: ;
		endcase
		return v;
	endfunction

	task directed_words();
		logic [OW-1:0] mx;
		mx = '1;
		send_word(OP_ADD, mx, mx);
		send_word(OP_ADD, '0, '0);
		send_word(OP_SUB, '0, mx);
		send_word(OP_SUB, OW'(5), OW'(7));
		send_word(OP_MUL, mx, mx);
		send_word(OP_MUL, OW'(sb.modulus - 1), OW'(sb.modulus - 1));
		send_word(OP_POW, OW'(3), '0);
		send_word(OP_POW, '0, '0);
		send_word(OP_POW, mx, mx);
		send_word(OP_POW, OW'(2), 63'h5555_5555_5555_5555);
		send_word(OP_INV, '0, OW'(9));
		send_word(OP_INV, OW'(sb.modulus), mx);
		send_word(OP_INV, OW'(2), '0);
		send_word(OP_DIV, OW'(10), '0);
		send_word(OP_DIV, OW'(10), OW'(sb.modulus * 3));
		send_word(OP_DIV, mx, OW'(3));
		send_word(3'd6, mx, mx);
		send_word(3'd7, OW'(1), OW'(1));
		start <= 0;
	endtask

	task random_words(int count);
		for (int i = 0; i < count; i++) begin
			send_word(3'($urandom_range(0, 7)), rand_operand(), rand_operand());
			maybe_idle();
		end
		start <= 0;
	endtask

	initial begin
		logic [31:0] settings[7];
		sb = new();
		quiet_tail = 0;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		start = 0; opcode = '0; operand_a = '0; operand_b = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_words();
		random_words(12);
		settings[0] = 32'd2;
		settings[1] = 32'h7fff_ffff;
		settings[2] = 32'h8000_0001;
		settings[3] = 32'd0;
		settings[4] = 32'd1000;
		settings[5] = 32'd65521;
		settings[6] = $urandom | 32'h1;
		for (int p = 0; p < 7; p++) begin
			wait_drained();
			write_modulus(settings[p]);
			@(posedge clk);
			if (p == 0 || p == 1) begin
				directed_words();
			end
			if (p == 6)
				quiet_tail = 1;
			random_words(p == 2 || p == 3 ? 6 : 12);
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.expected_residues.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
